/* rtl/ebcpu_pkg.sv */
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Opcode set, flag layout and result beat type for the 8-bit execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ebcpu_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
        OP_EOR = 6'd4,  OP_BIT = 6'd5,  OP_CMP = 6'd6,  OP_CPX = 6'd7,
        OP_CPY = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
        OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
        OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
        OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
        OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TSX = 6'd27,
        OP_TXA = 6'd28, OP_TXS = 6'd29, OP_TYA = 6'd30, OP_CLC = 6'd31,
        OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
        OP_SED = 6'd36, OP_SEI = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
        OP_BEQ = 6'd40, OP_BMI = 6'd41, OP_BNE = 6'd42, OP_BPL = 6'd43,
        OP_BVC = 6'd44, OP_BVS = 6'd45, OP_NOP = 6'd46, OP_PHA = 6'd47,
        OP_PHP = 6'd48, OP_PLA = 6'd49, OP_PLP = 6'd50
    } t_op;

    // Stored flags; bit 5 of the packed byte is not held
    typedef struct packed {
        logic n;
        logic v;
        logic b;
        logic d;
        logic i;
        logic z;
        logic c;
    } t_flags;

    localparam logic [7:0] STACK_START_RST = 8'hFF;
    localparam logic       STACK_PAGE      = 1'b1;

    typedef struct packed {
        logic [7:0] mem_value;
        logic       write_memory;
        logic       stack_access;
        logic [8:0] stack_address;
        logic       branch_taken;
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] sp_out;
        logic [7:0] status_out;
    } t_result;

    function automatic logic [7:0] pack_status(input t_flags f);
        return {f.n, f.v, 1'b1, f.b, f.d, f.i, f.z, f.c};
    endfunction

endpackage

`default_nettype wire

/* rtl/eight_bit_cpu_execute_unit.sv */
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Executes one 8-bit processor instruction per beat against A, X, Y, SP and
// the status flags; reports memory write, stack address, branch and registers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall     i_op, i_operand,
//                                                   i_to_accumulator
//  out       source     o_out_valid / i_out_stall   o_mem_value ... o_status_out
//  cfg       sink       i_cfg_wr_en                 i_cfg_wr_data (stack start)
//
//  One beat in per cycle unless o_in_stall is high; its result is registered.
//  Architectural registers update at the edge the input beat is taken.
//  The output register is backed by a one-entry skid buffer, so o_in_stall is
//  a registered signal that only rises when both are full.
//  Reset (synchronous, active low) clears A, X, Y and flags and loads SP with
//  0xFF; a cfg write loads SP with the new stack start at once; a beat taken
//  in the same cycle as a cfg write updates none of A, X, Y or the flags.
`default_nettype none

module eight_bit_cpu_execute_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [7:0]            i_cfg_wr_data,
    // input channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic [5:0]            i_op,
    input  wire logic [7:0]            i_operand,
    input  wire logic                  i_to_accumulator,
    // output channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [7:0]            o_mem_value,
    output      logic                  o_write_memory,
    output      logic                  o_stack_access,
    output      logic [8:0]            o_stack_address,
    output      logic                  o_branch_taken,
    output      logic [7:0]            o_acc_out,
    output      logic [7:0]            o_x_out,
    output      logic [7:0]            o_y_out,
    output      logic [7:0]            o_sp_out,
    output      logic [7:0]            o_status_out
);
    import ebcpu_pkg::*;

    // Architectural state
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_x, n_x;
    logic [7:0] r_y, n_y;
    logic [7:0] r_sp, n_sp;
    t_flags     r_flags, n_flags;

    // Output register and skid buffer
    t_result    r_out, r_skid, n_res;
    logic       r_out_valid, r_skid_valid;

    logic       w_in_beat;
    logic       w_main_free;
    t_op        w_op;

    assign w_op        = t_op'(i_op);
    assign w_in_beat   = i_in_valid & ~r_skid_valid;
    // main register can take new data this edge: empty, or being drained
    assign w_main_free = ~r_out_valid | ~i_out_stall;

    // ------------------------------------------------------------------------
    // Single-pass execute
    // ------------------------------------------------------------------------
    always_comb begin
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] cmp_reg;
        logic [7:0] diff;
        logic [7:0] src;
        logic [7:0] shr;
        logic [7:0] res8;

        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_flags = r_flags;

        n_res               = '0;
        n_res.mem_value     = '0;
        n_res.write_memory  = 1'b0;
        n_res.stack_access  = 1'b0;
        n_res.branch_taken  = 1'b0;

        // shared adder for ADC / SBC
        addend = (w_op == OP_SBC) ? ~i_operand : i_operand;
        sum    = {1'b0, r_acc} + {1'b0, addend} + {8'd0, r_flags.c};

        // shared subtractor for compares
        case (w_op)
            OP_CPX:  cmp_reg = r_x;
            OP_CPY:  cmp_reg = r_y;
            default: cmp_reg = r_acc;
        endcase
        diff = cmp_reg - i_operand;

        // shifter
        src = i_to_accumulator ? r_acc : i_operand;
        case (w_op)
            OP_ASL:  shr = {src[6:0], 1'b0};
            OP_LSR:  shr = {1'b0, src[7:1]};
            OP_ROL:  shr = {src[6:0], r_flags.c};
            default: shr = {r_flags.c, src[7:1]};
        endcase

        res8 = '0;

        unique case (w_op) inside
            OP_ADC, OP_SBC: begin
                res8      = sum[7:0];
                n_acc     = res8;
                n_flags.c = sum[8];
                n_flags.v = ((r_acc[7] ^ res8[7]) & (addend[7] ^ res8[7]));
                n_flags.z = (res8 == 8'd0);
                n_flags.n = res8[7];
            end
            OP_AND, OP_ORA, OP_EOR: begin
                if (w_op == OP_AND) begin
                    res8 = r_acc & i_operand;
                end else if (w_op == OP_ORA) begin
                    res8 = r_acc | i_operand;
                end else begin
                    res8 = r_acc ^ i_operand;
                end
                n_acc     = res8;
                n_flags.z = (res8 == 8'd0);
                n_flags.n = res8[7];
            end
            OP_BIT: begin
                n_flags.z = ((r_acc & i_operand) == 8'd0);
                n_flags.v = i_operand[6];
                n_flags.n = i_operand[7];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                n_flags.c = (cmp_reg >= i_operand);
                n_flags.z = (diff == 8'd0);
                n_flags.n = diff[7];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                n_flags.c = ((w_op == OP_ASL) || (w_op == OP_ROL)) ? src[7] : src[0];
                n_flags.z = (shr == 8'd0);
                n_flags.n = shr[7];
                if (i_to_accumulator) begin
                    n_acc = shr;
                end else begin
                    n_res.mem_value    = shr;
                    n_res.write_memory = 1'b1;
                end
            end
            OP_INC, OP_DEC: begin
                res8               = (w_op == OP_INC) ? i_operand + 8'd1
                                                      : i_operand - 8'd1;
                n_res.mem_value    = res8;
                n_res.write_memory = 1'b1;
                n_flags.z          = (res8 == 8'd0);
                n_flags.n          = res8[7];
            end
            OP_INX, OP_DEX, OP_LDX, OP_TAX, OP_TSX: begin
                case (w_op)
                    OP_INX:  res8 = r_x + 8'd1;
                    OP_DEX:  res8 = r_x - 8'd1;
                    OP_LDX:  res8 = i_operand;
                    OP_TAX:  res8 = r_acc;
                    default: res8 = r_sp;
                endcase
                n_x       = res8;
                n_flags.z = (res8 == 8'd0);
                n_flags.n = res8[7];
            end
            OP_INY, OP_DEY, OP_LDY, OP_TAY: begin
                case (w_op)
                    OP_INY:  res8 = r_y + 8'd1;
                    OP_DEY:  res8 = r_y - 8'd1;
                    OP_LDY:  res8 = i_operand;
                    default: res8 = r_acc;
                endcase
                n_y       = res8;
                n_flags.z = (res8 == 8'd0);
                n_flags.n = res8[7];
            end
            OP_LDA, OP_TXA, OP_TYA: begin
                case (w_op)
                    OP_LDA:  res8 = i_operand;
                    OP_TXA:  res8 = r_x;
                    default: res8 = r_y;
                endcase
                n_acc     = res8;
                n_flags.z = (res8 == 8'd0);
                n_flags.n = res8[7];
            end
            OP_STA: begin
                n_res.mem_value    = r_acc;
                n_res.write_memory = 1'b1;
            end
            OP_STX: begin
                n_res.mem_value    = r_x;
                n_res.write_memory = 1'b1;
            end
            OP_STY: begin
                n_res.mem_value    = r_y;
                n_res.write_memory = 1'b1;
            end
            OP_TXS: n_sp = r_x;
            OP_CLC: n_flags.c = 1'b0;
            OP_CLD: n_flags.d = 1'b0;
            OP_CLI: n_flags.i = 1'b0;
            OP_CLV: n_flags.v = 1'b0;
            OP_SEC: n_flags.c = 1'b1;
            OP_SED: n_flags.d = 1'b1;
            OP_SEI: n_flags.i = 1'b1;
            OP_BCC: n_res.branch_taken = ~r_flags.c;
            OP_BCS: n_res.branch_taken =  r_flags.c;
            OP_BEQ: n_res.branch_taken =  r_flags.z;
            OP_BMI: n_res.branch_taken =  r_flags.n;
            OP_BNE: n_res.branch_taken = ~r_flags.z;
            OP_BPL: n_res.branch_taken = ~r_flags.n;
            OP_BVC: n_res.branch_taken = ~r_flags.v;
            OP_BVS: n_res.branch_taken =  r_flags.v;
            OP_PHA, OP_PHP: begin
                n_res.mem_value    = (w_op == OP_PHA) ? r_acc : pack_status(r_flags);
                n_res.write_memory = 1'b1;
                n_res.stack_access = 1'b1;
                n_sp               = r_sp - 8'd1;
            end
            OP_PLA, OP_PLP: begin
                n_res.stack_access = 1'b1;
                n_sp               = r_sp + 8'd1;
                if (w_op == OP_PLA) begin
                    n_acc     = i_operand;
                    n_flags.z = (i_operand == 8'd0);
                    n_flags.n = i_operand[7];
                end else begin
                    // bit 5 of the pulled byte is dropped
                    n_flags = {i_operand[7:6], i_operand[4:0]};
                end
            end
            default: ;  // NOP and unassigned codes
        endcase

        // push addresses the old SP; everything else shows the SP after the step
        if ((w_op == OP_PHA) || (w_op == OP_PHP)) begin
            n_res.stack_address = {STACK_PAGE, r_sp};
        end else begin
            n_res.stack_address = {STACK_PAGE, n_sp};
        end

        n_res.acc_out    = n_acc;
        n_res.x_out      = n_x;
        n_res.y_out      = n_y;
        n_res.sp_out     = n_sp;
        n_res.status_out = pack_status(n_flags);
    end

    // ------------------------------------------------------------------------
    // Architectural registers and output control
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_sp          <= STACK_START_RST;
            r_flags       <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sp          <= i_cfg_wr_data;
            end else if (w_in_beat) begin
                r_acc   <= n_acc;
                r_x     <= n_x;
                r_y     <= n_y;
                r_sp    <= n_sp;
                r_flags <= n_flags;
            end

            if (w_main_free) begin
                // skid drains first; new beat cannot arrive while skid is full
                r_out_valid  <= r_skid_valid | w_in_beat;
                r_skid_valid <= 1'b0;
            end else if (w_in_beat) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_main_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_beat) begin
                r_out <= n_res;
            end
        end else if (w_in_beat) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_mem_value     = r_out.mem_value;
    assign o_write_memory  = r_out.write_memory;
    assign o_stack_access  = r_out.stack_access;
    assign o_stack_address = r_out.stack_address;
    assign o_branch_taken  = r_out.branch_taken;
    assign o_acc_out       = r_out.acc_out;
    assign o_x_out         = r_out.x_out;
    assign o_y_out         = r_out.y_out;
    assign o_sp_out        = r_out.sp_out;
    assign o_status_out    = r_out.status_out;

endmodule

`default_nettype wire

/* rtl/ebcpu_checker.sv */
// ----------------------------------------------------------------------------
// ebcpu_checker
// Port-level checks on the execute unit's output beats and flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module ebcpu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_mem_value,
    input wire logic       o_write_memory,
    input wire logic       o_stack_access,
    input wire logic [8:0] o_stack_address,
    input wire logic [7:0] o_sp_out,
    input wire logic [7:0] o_status_out
);

    // held beat must not move while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_mem_value) && $stable(o_status_out)
            && $stable(o_stack_address))
        else $error("output beat changed while stalled");

    // input side only stalls when a result is waiting
    a_stall_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output beat pending");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_memory |-> o_mem_value == 8'd0)
        else $error("mem value non-zero without write");

    a_status_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status_out[5] && o_stack_address[8])
        else $error("status bit 5 or stack page bit clear");

    // without a stack access the address tracks the reported SP
    a_addr_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_stack_access |-> o_stack_address[7:0] == o_sp_out)
        else $error("stack address does not match SP");

endmodule

bind eight_bit_cpu_execute_unit ebcpu_checker u_ebcpu_checker (.*);

`default_nettype wire
